// ===== sv/i2c_display_byte_writer_defines.svh =====
// assertion macros for the display byte writer
// used by the top level only, expects clk and rst_n in scope
`ifndef I2C_DISPLAY_BYTE_WRITER_DEFINES_SVH
`define I2C_DISPLAY_BYTE_WRITER_DEFINES_SVH

// same-cycle implication, off during reset
`define IDBW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("idbw same-cycle check failed");

// next-cycle implication, off during reset
`define IDBW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("idbw next-cycle check failed");

`endif

// ===== sv/idbw_pkg.sv =====
// shared types and constants for the display byte writer
// no dependencies
`default_nettype none

package idbw_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [7:0] ADDR_RESET = 8'h78;
    localparam logic [7:0] CTRL_CMD   = 8'h00;
    localparam logic [7:0] CTRL_DATA  = 8'h40;

    // step positions inside each segment
    localparam logic [4:0] START_LAST = 5'd3;
    localparam logic [4:0] BIT_LAST   = 5'd24;
    localparam logic [4:0] ACK_HIGH   = 5'd25;
    localparam logic [4:0] STOP_LAST  = 5'd2;
    localparam logic [1:0] PHASE_LAST = 2'd2;
    localparam logic [1:0] BYTE_LAST  = 2'd2;

    typedef enum logic {
        KIND_TICK  = 1'b0,
        KIND_WRITE = 1'b1
    } item_kind_t;

    typedef struct packed {
        item_kind_t  kind;
        logic        is_data;
        logic [7:0]  payload;
    } item_t;

    typedef struct packed {
        logic clock_line;
        logic data_line;
        logic busy_res;
        logic request_taken;
    } res_t;

endpackage

`default_nettype wire

// ===== sv/idbw_fifo.sv =====
// small first-word-fall-through queue of packed words
// no package dependencies
`default_nettype none

module idbw_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rdata,
    output logic                  empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// ===== sv/idbw_front.sv =====
// front end: classifies incoming items and queues them for the pin engine
// depends on idbw_pkg and idbw_fifo
`default_nettype none

module idbw_front
    import idbw_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic       mode,
    input  wire logic       is_data,
    input  wire logic [7:0] payload,
    output logic            item_valid,
    input  wire logic       item_pop,
    output item_t           item
);

    item_t                    item_in;
    logic [$bits(item_t)-1:0] item_raw;
    logic                     q_empty;

    // tick or write request
    assign item_in = '{
        kind:    (mode ? KIND_WRITE : KIND_TICK),
        is_data: is_data,
        payload: payload
    };

    idbw_fifo #(
        .WIDTH($bits(item_t)),
        .DEPTH(QUEUE_DEPTH)
    ) u_item_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (item_in),
        .full  (full),
        .pop   (item_pop),
        .rdata (item_raw),
        .empty (q_empty)
    );

    assign item_valid = !q_empty;
    assign item       = item_t'(item_raw);

endmodule

`default_nettype wire

// ===== sv/idbw_engine.sv =====
// back end: pin sequencer playing one bus step per tick, one result per item
// depends on idbw_pkg
`default_nettype none

module idbw_engine
    import idbw_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_write,
    input  wire logic [7:0] cfg_data,
    input  wire logic       item_valid,
    output logic            item_pop,
    input  wire item_t      item,
    input  wire logic       res_full,
    output logic            res_push,
    output res_t            res
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_START = 4'b0010,
        ST_BYTE  = 4'b0100,
        ST_STOP  = 4'b1000
    } eng_state_t;

    eng_state_t  state_reg, state_next;
    logic [7:0]  addr_reg;
    logic [23:0] shift_reg, shift_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [1:0]  phase_reg, phase_next;
    logic [1:0]  byte_reg, byte_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic        taken;

    assign item_pop = item_valid && !res_full;
    assign res_push = item_pop;

    always_comb
    begin
        state_next = state_reg;
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        byte_next  = byte_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        taken      = 1'b0;

        if (item_pop)
        begin
            if (item.kind == KIND_WRITE)
            begin
                // dropped while a transaction is running
                if (state_reg == ST_IDLE)
                begin
                    shift_next = {addr_reg, (item.is_data ? CTRL_DATA : CTRL_CMD),
                                  item.payload};
                    state_next = ST_START;
                    cnt_next   = '0;
                    taken      = 1'b1;
                end
            end
            else
            begin
                unique case (state_reg)
                    ST_IDLE:
                    begin
                    end
                    ST_START:
                    begin
                        cnt_next = cnt_reg + 1'b1;
                        if (cnt_reg == 5'd0)
                        begin
                            scl_next = 1'b1;
                        end
                        else if (cnt_reg == 5'd1)
                        begin
                            sda_next = 1'b1;
                        end
                        else if (cnt_reg == 5'd2)
                        begin
                            sda_next = 1'b0;
                        end
                        else if (cnt_reg == START_LAST)
                        begin
                            scl_next   = 1'b0;
                            state_next = ST_BYTE;
                            cnt_next   = '0;
                            byte_next  = '0;
                        end
                    end
                    ST_BYTE:
                    begin
                        cnt_next = cnt_reg + 1'b1;
                        if (cnt_reg == 5'd0)
                        begin
                            scl_next   = 1'b0;
                            phase_next = '0;
                        end
                        else if (cnt_reg <= BIT_LAST)
                        begin
                            // data bit, clock high, clock low
                            phase_next = (phase_reg == PHASE_LAST) ? '0 : phase_reg + 1'b1;
                            if (phase_reg == 2'd0)
                            begin
                                sda_next   = shift_reg[23];
                                shift_next = {shift_reg[22:0], 1'b0};
                            end
                            else if (phase_reg == 2'd1)
                            begin
                                scl_next = 1'b1;
                            end
                            else
                            begin
                                scl_next = 1'b0;
                            end
                        end
                        else if (cnt_reg == ACK_HIGH)
                        begin
                            // dummy ack clock, sda left alone
                            scl_next = 1'b1;
                        end
                        else
                        begin
                            scl_next = 1'b0;
                            cnt_next = '0;
                            if (byte_reg == BYTE_LAST)
                            begin
                                state_next = ST_STOP;
                            end
                            else
                            begin
                                byte_next = byte_reg + 1'b1;
                            end
                        end
                    end
                    ST_STOP:
                    begin
                        cnt_next = cnt_reg + 1'b1;
                        if (cnt_reg == 5'd0)
                        begin
                            scl_next = 1'b1;
                        end
                        else if (cnt_reg == 5'd1)
                        begin
                            sda_next = 1'b0;
                        end
                        else if (cnt_reg == STOP_LAST)
                        begin
                            sda_next   = 1'b1;
                            cnt_next   = '0;
                            state_next = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
        end
    end

    assign res = '{
        clock_line:    scl_next,
        data_line:     sda_next,
        busy_res:      (state_next != ST_IDLE),
        request_taken: taken
    };

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            addr_reg  <= ADDR_RESET;
            shift_reg <= '0;
            cnt_reg   <= '0;
            phase_reg <= '0;
            byte_reg  <= '0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            shift_reg <= shift_next;
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
            byte_reg  <= byte_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            if (cfg_write)
            begin
                addr_reg <= cfg_data;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/i2c_display_byte_writer.sv =====
// usage:
//   input queue: drive mode/is_data/payload with push; a request is taken at a
//   clock edge with push high and full low. mode 0 is one tick of bus time,
//   mode 1 asks for a new write (address byte, control byte, payload byte).
//   result queue: while empty is low the oldest result sits on clock_line,
//   data_line, busy_res and request_taken; pop high takes it.
//   every request gives exactly one result, in order.
//   a request passes the input queue, the sequencer and the result queue, in order.
//   throughput: one request per cycle while full is low; the pin sequencer retires
//   one per cycle while the result queue has room, one bus step per tick, 88 ticks a write.
//   reset: queues empty, both bus lines high, address byte 0x78.
//   if pop stays low the result queue fills, the sequencer holds, and full
//   rises once the input queue is also full; nothing is lost.
//   cfg_write loads the address byte; it takes effect on the next write.
// depends on idbw_pkg, idbw_front, idbw_engine, idbw_fifo and the defines header
`default_nettype none

`include "i2c_display_byte_writer_defines.svh"

module i2c_display_byte_writer
    import idbw_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // configuration
    input  wire logic       cfg_write,
    input  wire logic [7:0] cfg_data,
    // request side
    input  wire logic       push,
    output logic            full,
    input  wire logic       mode,
    input  wire logic       is_data,
    input  wire logic [7:0] payload,
    // result side
    output logic            empty,
    input  wire logic       pop,
    output logic            clock_line,
    output logic            data_line,
    output logic            busy_res,
    output logic            request_taken
);

    item_t                   item;
    logic                    item_valid;
    logic                    item_pop;
    logic                    res_full;
    logic                    res_push;
    res_t                    res_in;
    logic [$bits(res_t)-1:0] res_raw;
    res_t                    res_out;

    // front: classify and queue requests
    idbw_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .mode       (mode),
        .is_data    (is_data),
        .payload    (payload),
        .item_valid (item_valid),
        .item_pop   (item_pop),
        .item       (item)
    );

    // back: bus pin sequencer, one request retired per cycle while the result queue has room
    idbw_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item_pop   (item_pop),
        .item       (item),
        .res_full   (res_full),
        .res_push   (res_push),
        .res        (res_in)
    );

    // result queue decouples the sequencer from the consumer
    idbw_fifo #(
        .WIDTH($bits(res_t)),
        .DEPTH(QUEUE_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_raw),
        .empty (empty)
    );

    assign res_out       = res_t'(res_raw);
    assign clock_line    = res_out.clock_line;
    assign data_line     = res_out.data_line;
    assign busy_res      = res_out.busy_res;
    assign request_taken = res_out.request_taken;

    // a taken write always starts a transaction
    `IDBW_ASSERT_NOW(a_taken_busy, res_push && res_in.request_taken, res_in.busy_res)
    // bus lines are released high whenever no transaction runs
    `IDBW_ASSERT_NOW(a_idle_high, res_push && !res_in.busy_res, res_in.clock_line && res_in.data_line)
    // sequencer never retires a request without room for its result
    `IDBW_ASSERT_NOW(a_room, item_pop, !res_full && item_valid)
    // a retired request shows up in the result queue next cycle
    `IDBW_ASSERT_NEXT(a_result_lands, res_push, !empty)

endmodule

`default_nettype wire
